// File: rtl/tbah_pkg.sv
// ----------------------------------------------------------------------------
// tbah_pkg
// Shared types, sizes and helpers for the two-rate block average history.
// ----------------------------------------------------------------------------
package tbah_pkg;

  // decimation and history sizing
  localparam int RAW_SHORT_COUNT = 16;
  localparam int RAW_LONG_COUNT  = 64;
  localparam int HISTORY_DEPTH   = 32;
  localparam int MAX_READ_OUT    = 32;

  // field widths
  localparam int TEMP_W      = 16;
  localparam int PRESS_W     = 16;
  localparam int VIEW_W      = 2;
  localparam int VALUE_W     = 16;
  localparam int ENTRY_W     = TEMP_W + PRESS_W;
  localparam int FILL_W      = 8;
  localparam int TEMP_SUM_W  = 25;
  localparam int PRESS_SUM_W = 24;

  // ring addressing: one bit picks the ring, the rest pick the slot
  localparam int SLOT_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RING_ADDR_W = SLOT_W + 1;
  localparam int MEM_DEPTH   = 2 ** RING_ADDR_W;

  // beats per read
  localparam int READ_N   = (HISTORY_DEPTH > MAX_READ_OUT) ? MAX_READ_OUT : HISTORY_DEPTH;
  localparam int RD_CNT_W = $clog2(MAX_READ_OUT + 1);

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // view bit positions
  localparam int VIEW_PRESS_BIT = 0;
  localparam int VIEW_LONG_BIT  = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic wr_short;
    logic wr_long;
    logic start_read;
    logic rd_step;
  } cmd_t;

  typedef struct packed {
    logic short_full;
    logic long_full;
    logic out_free;
    logic rd_last;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) begin
      r = SLOT_W'(HISTORY_DEPTH - 1);
    end else begin
      r = s - 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/tbah_ctrl.sv
// ----------------------------------------------------------------------------
// tbah_ctrl
// Sequencer: accepts requests, orders ring writes, paces read beats.
// ----------------------------------------------------------------------------
module tbah_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_stall,
  input  tbah_pkg::sts_t sts_i,
  output tbah_pkg::cmd_t cmd_o
);

  tbah_pkg::state_t state_r;
  tbah_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbah_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbah_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == tbah_pkg::REQ_READ) ? tbah_pkg::ST_READ
                                                          : tbah_pkg::ST_UPDATE;
        end
      end
      tbah_pkg::ST_UPDATE: begin
        // both rings due: short this cycle, long the next
        if (!(sts_i.short_full && sts_i.long_full)) begin
          state_nxt = tbah_pkg::ST_IDLE;
        end
      end
      tbah_pkg::ST_READ: begin
        if (sts_i.out_free && sts_i.rd_last) begin
          state_nxt = tbah_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbah_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd_o    = '0;
    case (state_r)
      tbah_pkg::ST_IDLE: begin
        in_stall          = 1'b0;
        cmd_o.take_sample = in_valid && (in_req_type == tbah_pkg::REQ_SAMPLE);
        cmd_o.start_read  = in_valid && (in_req_type == tbah_pkg::REQ_READ);
      end
      tbah_pkg::ST_UPDATE: begin
        cmd_o.wr_short = sts_i.short_full;
        cmd_o.wr_long  = !sts_i.short_full && sts_i.long_full;
      end
      tbah_pkg::ST_READ: begin
        cmd_o.rd_step = sts_i.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/tbah_dp.sv
// ----------------------------------------------------------------------------
// tbah_dp
// Running sums, block averages, history memory and the output beat register.
// ----------------------------------------------------------------------------
module tbah_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tbah_pkg::cmd_t                       cmd_i,
  output tbah_pkg::sts_t                       sts_o,
  input  logic signed [tbah_pkg::TEMP_W-1:0]   temp_i,
  input  logic        [tbah_pkg::PRESS_W-1:0]  press_i,
  input  logic        [tbah_pkg::VIEW_W-1:0]   view_i,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tbah_pkg::VALUE_W-1:0]  out_value,
  output logic                                 out_is_last
);

  logic        [tbah_pkg::FILL_W-1:0]      short_fill_r, long_fill_r;
  logic signed [tbah_pkg::TEMP_SUM_W-1:0]  short_temp_r, long_temp_r;
  logic        [tbah_pkg::PRESS_SUM_W-1:0] short_press_r, long_press_r;
  logic        [tbah_pkg::SLOT_W-1:0]      short_pos_r, long_pos_r;
  logic        [tbah_pkg::MEM_DEPTH-1:0]   valid_r;
  logic        [tbah_pkg::RD_CNT_W-1:0]    rd_left_r;
  logic                                    out_vld_r;

  logic                                    rd_ring_r, rd_half_r;
  logic        [tbah_pkg::SLOT_W-1:0]      rd_slot_r;
  logic        [tbah_pkg::ENTRY_W-1:0]     rd_q_r;
  logic                                    mask_q_r, half_q_r, last_q_r;

  logic        [tbah_pkg::ENTRY_W-1:0]     mem [tbah_pkg::MEM_DEPTH];

  logic signed [tbah_pkg::TEMP_SUM_W-1:0]  temp_ext;
  logic        [tbah_pkg::PRESS_SUM_W-1:0] press_ext;
  logic signed [tbah_pkg::TEMP_SUM_W-1:0]  short_tavg, long_tavg;
  logic        [tbah_pkg::PRESS_SUM_W-1:0] short_pavg, long_pavg;
  logic                                    mem_we;
  logic        [tbah_pkg::RING_ADDR_W-1:0] wr_addr, rd_addr;
  logic        [tbah_pkg::ENTRY_W-1:0]     wr_data;
  logic        [tbah_pkg::SLOT_W-1:0]      start_pos;

  assign temp_ext  = tbah_pkg::TEMP_SUM_W'(temp_i);
  assign press_ext = tbah_pkg::PRESS_SUM_W'(press_i);

  // signed divide truncates toward zero
  assign short_tavg = short_temp_r / tbah_pkg::TEMP_SUM_W'(tbah_pkg::RAW_SHORT_COUNT);
  assign long_tavg  = long_temp_r / tbah_pkg::TEMP_SUM_W'(tbah_pkg::RAW_LONG_COUNT);
  assign short_pavg = short_press_r / tbah_pkg::PRESS_SUM_W'(tbah_pkg::RAW_SHORT_COUNT);
  assign long_pavg  = long_press_r / tbah_pkg::PRESS_SUM_W'(tbah_pkg::RAW_LONG_COUNT);

  assign mem_we  = cmd_i.wr_short || cmd_i.wr_long;
  assign wr_addr = cmd_i.wr_long ? {1'b1, long_pos_r} : {1'b0, short_pos_r};
  assign wr_data = cmd_i.wr_long
                 ? {long_pavg[tbah_pkg::PRESS_W-1:0], long_tavg[tbah_pkg::TEMP_W-1:0]}
                 : {short_pavg[tbah_pkg::PRESS_W-1:0], short_tavg[tbah_pkg::TEMP_W-1:0]};
  assign rd_addr = {rd_ring_r, rd_slot_r};

  assign start_pos = view_i[tbah_pkg::VIEW_LONG_BIT] ? long_pos_r : short_pos_r;

  assign sts_o.short_full = short_fill_r >= tbah_pkg::FILL_W'(tbah_pkg::RAW_SHORT_COUNT);
  assign sts_o.long_full  = long_fill_r >= tbah_pkg::FILL_W'(tbah_pkg::RAW_LONG_COUNT);
  assign sts_o.out_free   = !out_vld_r || !out_stall;
  assign sts_o.rd_last    = rd_left_r == tbah_pkg::RD_CNT_W'(1);

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_fill_r  <= '0;
      long_fill_r   <= '0;
      short_temp_r  <= '0;
      long_temp_r   <= '0;
      short_press_r <= '0;
      long_press_r  <= '0;
      short_pos_r   <= '0;
      long_pos_r    <= '0;
      valid_r       <= '0;
      rd_left_r     <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cmd_i.take_sample) begin
        short_fill_r  <= short_fill_r + 1'b1;
        long_fill_r   <= long_fill_r + 1'b1;
        short_temp_r  <= short_temp_r + temp_ext;
        long_temp_r   <= long_temp_r + temp_ext;
        short_press_r <= short_press_r + press_ext;
        long_press_r  <= long_press_r + press_ext;
      end
      if (cmd_i.wr_short) begin
        short_fill_r  <= '0;
        short_temp_r  <= '0;
        short_press_r <= '0;
        short_pos_r   <= tbah_pkg::slot_inc(short_pos_r);
      end
      if (cmd_i.wr_long) begin
        long_fill_r  <= '0;
        long_temp_r  <= '0;
        long_press_r <= '0;
        long_pos_r   <= tbah_pkg::slot_inc(long_pos_r);
      end
      if (mem_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd_i.start_read) begin
        rd_left_r <= tbah_pkg::RD_CNT_W'(tbah_pkg::READ_N);
      end else if (cmd_i.rd_step) begin
        rd_left_r <= rd_left_r - 1'b1;
      end
      if (cmd_i.rd_step) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // read walker and output beat payload
  always_ff @(posedge clk) begin
    if (cmd_i.start_read) begin
      rd_ring_r <= view_i[tbah_pkg::VIEW_LONG_BIT];
      rd_half_r <= view_i[tbah_pkg::VIEW_PRESS_BIT];
      rd_slot_r <= tbah_pkg::slot_dec(start_pos);
    end else if (cmd_i.rd_step) begin
      rd_slot_r <= tbah_pkg::slot_dec(rd_slot_r);
    end
    if (cmd_i.rd_step) begin
      mask_q_r <= valid_r[rd_addr];
      half_q_r <= rd_half_r;
      last_q_r <= sts_o.rd_last;
    end
  end

  // history memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_step) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // slots never written read as zero
  always_comb begin
    out_value = '0;
    if (mask_q_r) begin
      out_value = half_q_r ? rd_q_r[tbah_pkg::ENTRY_W-1:tbah_pkg::TEMP_W]
                           : rd_q_r[tbah_pkg::TEMP_W-1:0];
    end
  end

  assign out_valid   = out_vld_r;
  assign out_is_last = last_q_r;

`ifndef NO_ASSERTIONS
  a_short_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.wr_short |=> (short_fill_r == '0) && (short_temp_r == '0))
    else $error("short decimator not cleared after ring write");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (short_fill_r <= tbah_pkg::FILL_W'(tbah_pkg::RAW_SHORT_COUNT)) &&
    (long_fill_r <= tbah_pkg::FILL_W'(tbah_pkg::RAW_LONG_COUNT)))
    else $error("fill count overran block size");

  a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.rd_step |-> (rd_left_r != '0))
    else $error("read beat issued with no entries left");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(cmd_i.rd_step))
    else $error("output beat appeared without a read step");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !cmd_i.rd_step && !(cmd_i.wr_short && cmd_i.wr_long))
    else $error("history memory port oversubscribed");
`endif

endmodule

// File: rtl/two_rate_block_average_history.sv
// ----------------------------------------------------------------------------
// two_rate_block_average_history
// Short and long block averager of temperature/pressure with history readout.
// ----------------------------------------------------------------------------
// A sample beat passes the idle and the update state, and stays in update for
// the long ring write when the short and long blocks close on the same sample,
// since both history rings share one memory write port. A read beat emits one
// entry per cycle while out_stall is low (32 entries, newest first, is_last on
// the oldest); the next request is taken once the last entry has entered the
// output register. History contents reset to zero through per-entry valid
// bits that reset clears at once, so there is no clearing pass after reset.
module two_rate_block_average_history (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [tbah_pkg::TEMP_W-1:0]   in_temperature,
  input  logic        [tbah_pkg::PRESS_W-1:0]  in_pressure,
  input  logic        [tbah_pkg::VIEW_W-1:0]   in_view,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tbah_pkg::VALUE_W-1:0]  out_value,
  output logic                                 out_is_last
);

  tbah_pkg::cmd_t cmd;
  tbah_pkg::sts_t sts;

  tbah_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tbah_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .temp_i      (in_temperature),
    .press_i     (in_pressure),
    .view_i      (in_view),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_is_last (out_is_last)
  );

endmodule

// File: tb/two_rate_block_average_history_test.sv
// ----------------------------------------------------------------------------
// two_rate_block_average_history_test
// Drives samples and history reads into the two-rate block averager and
// checks every readout entry against a cycle-free model of both decimators
// and their rings. Starts with a fixed plan (reset contents, extreme samples,
// truncation toward zero, both blocks closing together), then random traffic
// with random gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module two_rate_block_average_history_test;

  localparam logic [tbah_pkg::VIEW_W-1:0] VIEW_SHORT_TEMP  = 2'd0;
  localparam logic [tbah_pkg::VIEW_W-1:0] VIEW_SHORT_PRESS = 2'd1;
  localparam logic [tbah_pkg::VIEW_W-1:0] VIEW_LONG_TEMP   = 2'd2;
  localparam logic [tbah_pkg::VIEW_W-1:0] VIEW_LONG_PRESS  = 2'd3;

  localparam int DEC_SHORT    = 0;
  localparam int DEC_LONG     = 1;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 700;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [tbah_pkg::VALUE_W-1:0] value;
    logic                                is_last;
  } entry_t;

  typedef struct packed {
    logic                                req;
    logic signed [tbah_pkg::TEMP_W-1:0]  temp;
    logic [tbah_pkg::PRESS_W-1:0]        press;
    logic [tbah_pkg::VIEW_W-1:0]         view;
    logic [7:0]                          reps;
    logic                                typed;   // newest entry given below, rest zero
    logic signed [tbah_pkg::VALUE_W-1:0] newest;
  } plan_row_t;

  localparam int PLAN_ROWS = 20;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // rings empty after reset
    '{tbah_pkg::REQ_READ,   16'sh1234, 16'hABCD, VIEW_SHORT_TEMP,  8'd1,  1'b1, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh7FFF, 16'hFFFF, VIEW_SHORT_PRESS, 8'd1,  1'b1, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh8000, 16'h0000, VIEW_LONG_TEMP,   8'd1,  1'b1, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'shFFFF, 16'h5A5A, VIEW_LONG_PRESS,  8'd1,  1'b1, 16'sd0},
    // one short block of extremes; pressure 0xFFFF reads back as -1
    '{tbah_pkg::REQ_SAMPLE, 16'sh8000, 16'hFFFF, VIEW_LONG_PRESS,  8'd16, 1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_SHORT_TEMP,  8'd1,  1'b1, 16'sh8000},
    '{tbah_pkg::REQ_READ,   16'sh0F0F, 16'hF0F0, VIEW_SHORT_PRESS, 8'd1,  1'b1, -16'sd1},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_LONG_TEMP,   8'd1,  1'b1, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_LONG_PRESS,  8'd1,  1'b1, 16'sd0},
    '{tbah_pkg::REQ_SAMPLE, 16'sh7FFF, 16'h0000, VIEW_LONG_TEMP,   8'd16, 1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_SHORT_TEMP,  8'd1,  1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_SHORT_PRESS, 8'd1,  1'b0, 16'sd0},
    // negative sum that is not a multiple of the block size
    '{tbah_pkg::REQ_SAMPLE, 16'sh0000, 16'h0001, VIEW_SHORT_PRESS, 8'd15, 1'b0, 16'sd0},
    '{tbah_pkg::REQ_SAMPLE, -16'sd17,  16'h0002, VIEW_SHORT_TEMP,  8'd1,  1'b0, 16'sd0},
    // 64th sample closes the short and the long block together
    '{tbah_pkg::REQ_SAMPLE, 16'sd100,  16'd40000, VIEW_LONG_PRESS, 8'd15, 1'b0, 16'sd0},
    '{tbah_pkg::REQ_SAMPLE, 16'sd9,    16'd7,    VIEW_SHORT_TEMP,  8'd1,  1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_SHORT_TEMP,  8'd1,  1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_SHORT_PRESS, 8'd1,  1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_LONG_TEMP,   8'd1,  1'b0, 16'sd0},
    '{tbah_pkg::REQ_READ,   16'sh0000, 16'h0000, VIEW_LONG_PRESS,  8'd1,  1'b0, 16'sd0}
  };

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_req_type;
  logic signed [tbah_pkg::TEMP_W-1:0]  in_temperature;
  logic [tbah_pkg::PRESS_W-1:0]        in_pressure;
  logic [tbah_pkg::VIEW_W-1:0]         in_view;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [tbah_pkg::VALUE_W-1:0] out_value;
  logic                                out_is_last;

  two_rate_block_average_history dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_temperature (in_temperature),
    .in_pressure    (in_pressure),
    .in_view        (in_view),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_is_last    (out_is_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // decimator model: running sums, fill counts and both rings
  int                           dec_fill [2];
  int                           dec_tsum [2];
  int                           dec_psum [2];
  int                           dec_wpos [2];
  logic [tbah_pkg::ENTRY_W-1:0] dec_ring [2][tbah_pkg::HISTORY_DEPTH];

  entry_t pending_entries [$];
  int     mismatches;
  int     entries_seen;

  initial begin
    for (int d = 0; d < 2; d++) begin
      dec_fill[d] = 0;
      dec_tsum[d] = 0;
      dec_psum[d] = 0;
      dec_wpos[d] = 0;
      for (int s = 0; s < tbah_pkg::HISTORY_DEPTH; s++) begin
        dec_ring[d][s] = '0;
      end
    end
  end

  function automatic void accumulate_sample(input int d, input int blk,
                                            input logic signed [tbah_pkg::TEMP_W-1:0] t,
                                            input logic [tbah_pkg::PRESS_W-1:0] p);
    int avg_t;
    int avg_p;
    dec_tsum[d] += t;
    dec_psum[d] += int'(p);
    dec_fill[d]++;
    if (dec_fill[d] >= blk) begin
      avg_t = dec_tsum[d] / blk;   // truncates toward zero
      avg_p = dec_psum[d] / blk;
      dec_ring[d][dec_wpos[d]] = {avg_p[tbah_pkg::PRESS_W-1:0], avg_t[tbah_pkg::TEMP_W-1:0]};
      dec_wpos[d] = (dec_wpos[d] + 1) % tbah_pkg::HISTORY_DEPTH;
      dec_fill[d] = 0;
      dec_tsum[d] = 0;
      dec_psum[d] = 0;
    end
  endfunction

  function automatic void queue_view_readout(input logic [tbah_pkg::VIEW_W-1:0] v,
                                             input logic typed,
                                             input logic signed [tbah_pkg::VALUE_W-1:0] newest);
    int                           d;
    int                           slot;
    logic [tbah_pkg::ENTRY_W-1:0] e;
    entry_t                       x;
    d = v[tbah_pkg::VIEW_LONG_BIT] ? DEC_LONG : DEC_SHORT;
    for (int i = 0; i < tbah_pkg::READ_N; i++) begin
      slot = (dec_wpos[d] + tbah_pkg::HISTORY_DEPTH - 1 - i) % tbah_pkg::HISTORY_DEPTH;
      e = dec_ring[d][slot];
      x.value = v[tbah_pkg::VIEW_PRESS_BIT] ? e[tbah_pkg::ENTRY_W-1:tbah_pkg::TEMP_W]
                                            : e[tbah_pkg::TEMP_W-1:0];
      if (typed) begin
        x.value = (i == 0) ? newest : '0;
      end
      x.is_last = (i == tbah_pkg::READ_N - 1);
      pending_entries.push_back(x);
    end
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] field_value();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_beat(input logic req,
                            input logic signed [tbah_pkg::TEMP_W-1:0] t,
                            input logic [tbah_pkg::PRESS_W-1:0] p,
                            input logic [tbah_pkg::VIEW_W-1:0] v,
                            input logic typed,
                            input logic signed [tbah_pkg::VALUE_W-1:0] newest);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_temperature <= t;
    in_pressure    <= p;
    in_view        <= v;
    do @(posedge clk); while (in_stall);
    if (req == tbah_pkg::REQ_SAMPLE) begin
      accumulate_sample(DEC_SHORT, tbah_pkg::RAW_SHORT_COUNT, t, p);
      accumulate_sample(DEC_LONG, tbah_pkg::RAW_LONG_COUNT, t, p);
    end else begin
      queue_view_readout(v, typed, newest);
    end
    @(negedge clk);
  endtask

  task automatic rest_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic flag_mismatch(input entry_t want, input entry_t got);
    if (mismatches < MAX_REPORTS) begin
      $display("readout mismatch at %0t: value %0d (want %0d), is_last %0b (want %0b)",
               $time, got.value, want.value, got.is_last, want.is_last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : check_beat
    entry_t got;
    entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.value   = out_value;
      got.is_last = out_is_last;
      entries_seen++;
      if (pending_entries.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected beat at %0t: value %0d is_last %0b",
                   $time, got.value, got.is_last);
        end
        mismatches++;
      end else begin
        want = pending_entries.pop_front();
        if (got !== want) begin
          flag_mismatch(want, got);
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold
  initial begin : receiver
    int  stall_left;
    int  cyc;
    bit  hold_done;
    out_stall  = 1'b0;
    stall_left = 0;
    cyc        = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && entries_seen >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = ((cyc / 200) % 4 == 1) ? 0 : idle_len();
      end
    end
  end

  initial begin : sender
    plan_row_t                   row;
    logic                        req;
    logic [tbah_pkg::VIEW_W-1:0] v;
    int                          gap;
    mismatches     = 0;
    entries_seen   = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = tbah_pkg::REQ_SAMPLE;
    in_temperature = '0;
    in_pressure    = '0;
    in_view        = VIEW_SHORT_TEMP;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      for (int k = 0; k < row.reps; k++) begin
        offer_beat(row.req, row.temp, row.press, row.view, row.typed, row.newest);
        rest_sender(idle_len());
      end
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      req = ($urandom_range(0, 99) < 10) ? tbah_pkg::REQ_READ : tbah_pkg::REQ_SAMPLE;
      v   = tbah_pkg::VIEW_W'($urandom_range(VIEW_SHORT_TEMP, VIEW_LONG_PRESS));
      offer_beat(req, field_value(), field_value(), v, 1'b0, '0);
      gap = ((k / 48) % 4 == 2) ? 0 : idle_len();
      rest_sender(gap);
    end
    in_valid <= 1'b0;

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("** two_rate_block_average_history: PASSED **");
    end else begin
      $display("** two_rate_block_average_history: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("** two_rate_block_average_history: FAILED **");
    $finish;
  end

endmodule
